// ===== design/simd_mersenne_twister_generator_macros.svh =====
// Assertion macros for the SIMD Mersenne Twister generator.
// Included by the top level; depends on nothing else.
`ifndef SIMD_MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define SIMD_MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMTG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/smtg_pkg.sv =====
// Shared types, codes and default constants for the SIMD Mersenne Twister generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package smtg_pkg;

    // Word geometry.
    localparam int LANES         = 4;
    localparam int LANE_W        = 32;
    localparam int WORD_W        = LANES * LANE_W;
    localparam int BITS_PER_BYTE = 8;
    localparam int LOAD_INDEX_W  = 8;
    localparam int S_TDATA_W     = LOAD_INDEX_W + WORD_W;
    localparam int M_TDATA_W     = WORD_W;
    localparam int CFG_IDX_W     = 2;

    // Default recursion parameters of the 19937 variant.
    localparam int RING_WORDS_DEF       = 156;
    localparam int MIDDLE_OFFSET_DEF    = 122;
    localparam int LANE_LEFT_SHIFT_DEF  = 18;
    localparam int BYTE_LEFT_SHIFT_DEF  = 1;
    localparam int LANE_RIGHT_SHIFT_DEF = 11;
    localparam int BYTE_RIGHT_SHIFT_DEF = 1;

    typedef logic [LANE_W-1:0] lane_t;
    // Lane 0 sits in the least significant bits.
    typedef lane_t [LANES-1:0] word_t;

    // Mask register values after reset.
    localparam lane_t LANE0_MASK_RST = 32'hDFFF_FFEF;
    localparam lane_t LANE1_MASK_RST = 32'hDDFE_CB7F;
    localparam lane_t LANE2_MASK_RST = 32'hBFFA_FFFF;
    localparam lane_t LANE3_MASK_RST = 32'hBFFF_FFF6;

    // Item kinds.
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_GEN  = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LANE0_MASK = 2'd0,
        CFG_LANE1_MASK = 2'd1,
        CFG_LANE2_MASK = 2'd2,
        CFG_LANE3_MASK = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/smtg_ring.sv =====
// State ring memory: one write port, two registered read ports, with write bypass.
// Depends on smtg_pkg for the word type.
`default_nettype none

module smtg_ring #(
    parameter int DEPTH = smtg_pkg::RING_WORDS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire smtg_pkg::word_t          wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output smtg_pkg::word_t               rd_data_a,
    output smtg_pkg::word_t               rd_data_b
);
    import smtg_pkg::*;

    word_t mem [DEPTH];
    word_t q_a_reg;
    word_t q_b_reg;
    word_t byp_reg;
    logic  fwd_a_reg;
    logic  fwd_b_reg;

    // Plain memory write and registered reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_a_reg <= mem[rd_addr_a];
            q_b_reg <= mem[rd_addr_b];
        end
    end

    // A read that meets a write of the same entry in the same cycle takes the new word.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_a_reg <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg <= wr_en && (wr_addr == rd_addr_b);
            byp_reg   <= wr_data;
        end
    end

    assign rd_data_a = fwd_a_reg ? byp_reg : q_a_reg;
    assign rd_data_b = fwd_b_reg ? byp_reg : q_b_reg;

endmodule

`default_nettype wire

// ===== design/smtg_recur.sv =====
// One step of the XOR-shift recursion on four 128-bit state words.
// Depends on smtg_pkg for the word type and byte width.
`default_nettype none

module smtg_recur #(
    parameter int LANE_LEFT_SHIFT  = smtg_pkg::LANE_LEFT_SHIFT_DEF,
    parameter int BYTE_LEFT_SHIFT  = smtg_pkg::BYTE_LEFT_SHIFT_DEF,
    parameter int LANE_RIGHT_SHIFT = smtg_pkg::LANE_RIGHT_SHIFT_DEF,
    parameter int BYTE_RIGHT_SHIFT = smtg_pkg::BYTE_RIGHT_SHIFT_DEF
) (
    input  wire smtg_pkg::word_t word_a,
    input  wire smtg_pkg::word_t word_b,
    input  wire smtg_pkg::word_t word_c,
    input  wire smtg_pkg::word_t word_d,
    input  wire smtg_pkg::word_t masks,
    output smtg_pkg::word_t      result
);
    import smtg_pkg::*;

    localparam int LEFT_BITS  = BYTE_LEFT_SHIFT * BITS_PER_BYTE;
    localparam int RIGHT_BITS = BYTE_RIGHT_SHIFT * BITS_PER_BYTE;

    word_t shl_a;
    word_t shr_c;

    // Whole-word byte shifts of the current word and the word two back.
    assign shl_a = word_a << LEFT_BITS;
    assign shr_c = word_c >> RIGHT_BITS;

    // Lane-wise terms from the middle word and the word one back.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            result[k] = word_a[k] ^ shl_a[k] ^ ((word_b[k] >> LANE_RIGHT_SHIFT) & masks[k])
                      ^ shr_c[k] ^ (word_d[k] << LANE_LEFT_SHIFT);
        end
    end

endmodule

`default_nettype wire

// ===== design/simd_mersenne_twister_generator.sv =====
// Top level of the SIMD Mersenne Twister generator: pointer, ring reads, output register.
// Depends on smtg_pkg, smtg_ring, smtg_recur and the assertion macro header.
//
//   Channel   Direction  Payload
//   s_        in         tuser: cmd; tdata: load_index, load_lane0..load_lane3
//   m_        out        tdata: out_lane0..out_lane3
//   cfg_      in         cfg_idx selects a lane mask, cfg_data is the value
//
// One item is taken every cycle unless the output stalls. A generate item's word passes
// through the registered read of the two ring copies, then the output register, to m_tdata.
// A load item gives no result. Reset clears the pointer and the valid flags and sets the
// masks to their reset values; the ring itself holds nothing defined until written and
// needs no clearing pass. A stalled output holds the item in flight and drops s_tready.
`default_nettype none

`include "simd_mersenne_twister_generator_macros.svh"

module simd_mersenne_twister_generator #(
    parameter int RING_WORDS       = smtg_pkg::RING_WORDS_DEF,
    parameter int MIDDLE_OFFSET    = smtg_pkg::MIDDLE_OFFSET_DEF,
    parameter int LANE_LEFT_SHIFT  = smtg_pkg::LANE_LEFT_SHIFT_DEF,
    parameter int BYTE_LEFT_SHIFT  = smtg_pkg::BYTE_LEFT_SHIFT_DEF,
    parameter int LANE_RIGHT_SHIFT = smtg_pkg::LANE_RIGHT_SHIFT_DEF,
    parameter int BYTE_RIGHT_SHIFT = smtg_pkg::BYTE_RIGHT_SHIFT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [smtg_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [smtg_pkg::LANE_W-1:0]    cfg_data,
    // Input items.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] load_index, [39:8] load_lane0, [71:40] load_lane1,
    // [103:72] load_lane2, [135:104] load_lane3
    input  wire logic [smtg_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  wire logic                           s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] out_lane0, [63:32] out_lane1, [95:64] out_lane2, [127:96] out_lane3
    output logic [smtg_pkg::M_TDATA_W-1:0]      m_tdata
);
    import smtg_pkg::*;

    localparam int AW      = $clog2(RING_WORDS);
    localparam int MID_MOD = MIDDLE_OFFSET % RING_WORDS;
    localparam int XW      = AW + LOAD_INDEX_W;

    // Configuration registers.
    word_t masks_reg;
    word_t masks_next;

    // Ring pointer.
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [AW:0]   ptr_ext;
    logic [AW:0]   mid_sum;
    logic [AW:0]   back2_sum;
    logic [AW:0]   back1_sum;
    logic [AW:0]   inc_sum;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] addr_c;
    logic [AW-1:0] addr_d;

    // Stage holding the item while its ring words are read.
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    cmd_t                    s1_cmd_reg;
    logic [LOAD_INDEX_W-1:0] s1_idx_reg;
    word_t                   s1_word_reg;
    logic [AW-1:0]           s1_ptr_reg;

    // Output register.
    logic  m_tvalid_reg;
    logic  m_tvalid_next;
    word_t m_tdata_reg;

    logic          s_accept;
    cmd_t          s_cmd;
    logic          s1_gen;
    logic          s1_go;
    logic          out_free;
    logic          load_in_range;
    logic [XW-1:0] load_idx_ext;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;
    word_t         word_a;
    word_t         word_b;
    word_t         word_c;
    word_t         word_d;
    word_t         gen_word;

    // Handshake and flow control.
    assign s_cmd    = cmd_t'(s_tuser);
    assign s1_gen   = (s1_cmd_reg == CMD_GEN);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_go    = s1_valid_reg && (!s1_gen || out_free);
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;

    // Read addresses of the four words the recursion uses, all modulo the ring size.
    always_comb begin
        ptr_ext   = {1'b0, ptr_reg};
        mid_sum   = ptr_ext + (AW+1)'(MID_MOD);
        back2_sum = (ptr_ext >= (AW+1)'(2)) ? ptr_ext - (AW+1)'(2)
                                            : ptr_ext + (AW+1)'(RING_WORDS - 2);
        back1_sum = (ptr_ext >= (AW+1)'(1)) ? ptr_ext - (AW+1)'(1)
                                            : ptr_ext + (AW+1)'(RING_WORDS - 1);
        inc_sum   = ptr_ext + (AW+1)'(1);
        if (mid_sum >= (AW+1)'(RING_WORDS)) begin
            mid_sum = mid_sum - (AW+1)'(RING_WORDS);
        end
        addr_a = ptr_reg;
        addr_b = mid_sum[AW-1:0];
        addr_c = back2_sum[AW-1:0];
        addr_d = back1_sum[AW-1:0];
    end

    // Pointer: advances on a generate item, cleared by a load item.
    always_comb begin
        ptr_next = ptr_reg;
        if (s_accept) begin
            if (s_cmd == CMD_LOAD) begin
                ptr_next = '0;
            end else if (inc_sum == (AW+1)'(RING_WORDS)) begin
                ptr_next = '0;
            end else begin
                ptr_next = inc_sum[AW-1:0];
            end
        end
    end

    // Mask register writes.
    always_comb begin
        masks_next = masks_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_idx))
                CFG_LANE0_MASK: masks_next[0] = cfg_data;
                CFG_LANE1_MASK: masks_next[1] = cfg_data;
                CFG_LANE2_MASK: masks_next[2] = cfg_data;
                CFG_LANE3_MASK: masks_next[3] = cfg_data;
            endcase
        end
    end

    // Ring write: the new word of a generate item, or a loaded word in range.
    assign load_idx_ext  = XW'(s1_idx_reg);
    assign load_in_range = (load_idx_ext < XW'(RING_WORDS));
    assign wr_en         = s1_go && (s1_gen || load_in_range);
    assign wr_addr       = s1_gen ? s1_ptr_reg : load_idx_ext[AW-1:0];
    assign wr_data       = s1_gen ? gen_word : s1_word_reg;

    // Two identical copies of the ring give the four reads each cycle.
    smtg_ring #(
        .DEPTH (RING_WORDS)
    ) u_ring_ab (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (s_accept),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (word_a),
        .rd_data_b (word_b)
    );

    smtg_ring #(
        .DEPTH (RING_WORDS)
    ) u_ring_cd (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (s_accept),
        .rd_addr_a (addr_c),
        .rd_addr_b (addr_d),
        .rd_data_a (word_c),
        .rd_data_b (word_d)
    );

    smtg_recur #(
        .LANE_LEFT_SHIFT  (LANE_LEFT_SHIFT),
        .BYTE_LEFT_SHIFT  (BYTE_LEFT_SHIFT),
        .LANE_RIGHT_SHIFT (LANE_RIGHT_SHIFT),
        .BYTE_RIGHT_SHIFT (BYTE_RIGHT_SHIFT)
    ) u_recur (
        .word_a (word_a),
        .word_b (word_b),
        .word_c (word_c),
        .word_d (word_d),
        .masks  (masks_reg),
        .result (gen_word)
    );

    // Valid flags of the read stage and the output register.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (s1_go && s1_gen) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            masks_reg    <= {LANE3_MASK_RST, LANE2_MASK_RST, LANE1_MASK_RST, LANE0_MASK_RST};
        end else begin
            ptr_reg      <= ptr_next;
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            masks_reg    <= masks_next;
        end
    end

    // Payload of the read stage and the output register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg  <= s_cmd;
            s1_idx_reg  <= s_tdata[LOAD_INDEX_W-1:0];
            s1_word_reg <= s_tdata[S_TDATA_W-1:LOAD_INDEX_W];
            s1_ptr_reg  <= ptr_reg;
        end
        if (s1_go && s1_gen) begin
            m_tdata_reg <= gen_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The pointer never leaves the ring.
    `SMTG_ASSERT_SAME(a_ptr_in_ring, aclk, aresetn, 1'b1, ({1'b0, ptr_reg} < (AW+1)'(RING_WORDS)), "ring pointer out of range")
    // An accepted load item restarts the recursion at the first word.
    `SMTG_ASSERT_NEXT(a_load_clears_ptr, aclk, aresetn, s_accept && (s_cmd == CMD_LOAD), (ptr_reg == '0), "load item did not clear the pointer")
    // A generate item leaving the read stage is the next word shown.
    `SMTG_ASSERT_NEXT(a_gen_reaches_out, aclk, aresetn, s1_go && s1_gen, m_tvalid_reg && (m_tdata_reg == $past(gen_word)), "generated word lost")
    // A load item never produces a result.
    `SMTG_ASSERT_NEXT(a_load_no_result, aclk, aresetn, s1_go && !s1_gen && !m_tvalid_reg, !m_tvalid_reg, "load item produced a result")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SIMD Mersenne Twister generator: loads the state ring,
// runs the recursion under several mask settings and checks every generated word.
// Depends on smtg_pkg and the simd_mersenne_twister_generator top level.
module tb_top;
    import smtg_pkg::*;

    localparam int DRAIN_CYCLES    = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 120;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx  = CFG_LANE0_MASK;
    logic [LANE_W-1:0]        cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata  = '0;
    logic                     s_tuser  = CMD_LOAD;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;

    // Private copy of the block state, kept in step with every accepted item.
    word_t       ring_copy [RING_WORDS_DEF];
    int unsigned ring_ptr = 0;
    lane_t       mask_copy [LANES] = '{LANE0_MASK_RST, LANE1_MASK_RST,
                                       LANE2_MASK_RST, LANE3_MASK_RST};
    word_t       pending_words [$];

    int unsigned error_count    = 0;
    int unsigned idle_cycles    = 0;
    bit          tx_idles       = 1'b1;
    bit          rx_idles       = 1'b1;
    int          rx_hold_cycles = 0;

    simd_mersenne_twister_generator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // One step of the recursion on the four words it reads.
    function automatic word_t twist_word(input word_t a, input word_t b,
                                         input word_t c, input word_t d);
        word_t a_shl;
        word_t c_shr;
        word_t r;
        int    k;
        a_shl = a << (BITS_PER_BYTE * BYTE_LEFT_SHIFT_DEF);
        c_shr = c >> (BITS_PER_BYTE * BYTE_RIGHT_SHIFT_DEF);
        for (k = 0; k < LANES; k++) begin
            r[k] = a[k] ^ a_shl[k] ^ ((b[k] >> LANE_RIGHT_SHIFT_DEF) & mask_copy[k])
                 ^ c_shr[k] ^ (d[k] << LANE_LEFT_SHIFT_DEF);
        end
        return r;
    endfunction

    // Apply one accepted item to the state copy and queue the word it should produce.
    function automatic void advance_ring(input cmd_t cmd, input logic [LOAD_INDEX_W-1:0] idx,
                                         input word_t w);
        int unsigned p;
        word_t       r;
        if (cmd == CMD_LOAD) begin
            // An index past the ring writes nothing but still clears the pointer.
            if (idx < RING_WORDS_DEF) ring_copy[idx] = w;
            ring_ptr = 0;
        end else begin
            p = ring_ptr;
            r = twist_word(ring_copy[p],
                           ring_copy[(p + MIDDLE_OFFSET_DEF) % RING_WORDS_DEF],
                           ring_copy[(p + RING_WORDS_DEF - 2) % RING_WORDS_DEF],
                           ring_copy[(p + RING_WORDS_DEF - 1) % RING_WORDS_DEF]);
            ring_copy[p] = r;
            pending_words.push_back(r);
            ring_ptr = (p + 1 == RING_WORDS_DEF) ? 0 : p + 1;
        end
    endfunction

    function automatic lane_t rand_lane();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t rand_word();
        word_t w;
        int    k;
        for (k = 0; k < LANES; k++) begin
            w[k] = rand_lane();
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input cmd_t cmd, input logic [LOAD_INDEX_W-1:0] idx,
                             input word_t w);
        if (tx_idles && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {w, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_ring(cmd, idx, w);
    endtask

    task automatic send_load(input logic [LOAD_INDEX_W-1:0] idx, input word_t w);
        send_item(CMD_LOAD, idx, w);
    endtask

    // The load fields of a generate item are ignored, so they carry noise.
    task automatic send_gen();
        send_item(CMD_GEN, LOAD_INDEX_W'($urandom_range(255)), rand_word());
    endtask

    // Stop offering items, wait for every expected word, then let loads settle.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_reg_t r, input lane_t v);
        cfg_we   <= 1'b1;
        cfg_idx  <= r;
        cfg_data <= v;
        @(posedge aclk);
        mask_copy[r] = v;
    endtask

    task automatic set_masks(input lane_t m0, input lane_t m1, input lane_t m2, input lane_t m3);
        wait_for_idle();
        write_cfg(CFG_LANE0_MASK, m0);
        write_cfg(CFG_LANE1_MASK, m1);
        write_cfg(CFG_LANE2_MASK, m2);
        write_cfg(CFG_LANE3_MASK, m3);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Runs of generate items of random length, each closed by one or two reloads.
    task automatic run_bursts(input int n_items, input int max_run);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items) begin
            run_len = $urandom_range(1, max_run);
            repeat (run_len) send_gen();
            sent += run_len;
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(9) == 0)
                    send_load(LOAD_INDEX_W'($urandom_range(255, RING_WORDS_DEF)), rand_word());
                else
                    send_load(LOAD_INDEX_W'($urandom_range(RING_WORDS_DEF - 1)), rand_word());
                sent++;
            end
        end
    endtask

    // Every word must be written before the recursion may read it.
    task automatic test_fill_ring();
        int i;
        for (i = 0; i < RING_WORDS_DEF; i++) begin
            send_load(LOAD_INDEX_W'(i), rand_word());
        end
    endtask

    // Extreme words, both ends of the ring and loads beyond it.
    task automatic test_directed();
        send_load(LOAD_INDEX_W'(0), '1);
        send_load(LOAD_INDEX_W'(RING_WORDS_DEF - 1), '0);
        send_gen();
        send_gen();
        send_load(8'hFF, rand_word());
        send_gen();
        send_load(LOAD_INDEX_W'(RING_WORDS_DEF), '1);
        send_gen();
        send_load(LOAD_INDEX_W'(MIDDLE_OFFSET_DEF), '1);
        send_load(LOAD_INDEX_W'(128), {LANES{32'h8000_0001}});
        send_gen();
        send_gen();
        send_load(LOAD_INDEX_W'(1), '0);
        send_gen();
        send_gen();
    endtask

    // A long unbroken run that wraps the pointer twice, with no idling on either side.
    task automatic test_pointer_wrap();
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        send_load(LOAD_INDEX_W'($urandom_range(255, RING_WORDS_DEF)), rand_word());
        repeat (2 * RING_WORDS_DEF + 20) send_gen();
        tx_idles = 1'b1;
        rx_idles = 1'b1;
    endtask

    task automatic test_mask_settings();
        set_masks('0, '0, '0, '0);
        run_bursts(130, 40);
        set_masks('1, '1, '1, '1);
        run_bursts(130, 40);
        set_masks(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        run_bursts(130, 40);
        set_masks($urandom, $urandom, $urandom, $urandom);
        run_bursts(130, 40);
        set_masks(LANE0_MASK_RST, LANE1_MASK_RST, LANE2_MASK_RST, LANE3_MASK_RST);
        run_bursts(130, 40);
    endtask

    // The receiver holds off while items keep coming, so the block must stall its input.
    task automatic test_backpressure();
        wait_for_idle();
        rx_hold_cycles = HOLD_OFF_CYCLES;
        repeat (40) send_gen();
        wait_for_idle();
        send_gen();
    endtask

    task automatic test_random_mix();
        run_bursts(500, 200);
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready <= !rx_idles || ($urandom_range(99) >= 10);
        end
    end

    // Compare each result item with the oldest expected word, lane by lane.
    always @(posedge aclk) begin : check_results
        word_t got;
        word_t want;
        int    k;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = pending_words.pop_front();
                for (k = 0; k < LANES; k++) begin
                    if (got[k] !== want[k])
                        report_mismatch($sformatf("out_lane%0d is %h, expected %h",
                                                  k, got[k], want[k]));
                end
            end
        end
    end

    // Ends the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_fill_ring();
        test_directed();
        test_pointer_wrap();
        test_mask_settings();
        test_backpressure();
        test_random_mix();
        wait_for_idle();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/smtg_pkg.sv
design/smtg_ring.sv
design/smtg_recur.sv
design/simd_mersenne_twister_generator.sv
tb/tb_top.sv
